@@ hw/rtl/nrn_pkg.sv @@
// nrn_pkg: shared types and constants of the nth regular number block.
// No dependencies; imported by nrn_alu, nrn_seq and nth_regular_number.
package nrn_pkg;

   localparam int N_WIDTH     = 12;   // width of the requested index
   localparam int OUT_WIDTH   = 48;   // width of the returned value
   localparam int LIMIT_WIDTH = 14;   // wide enough for an index limit up to 16383

   // Factor applied by the shared arithmetic unit.
   typedef enum logic [1:0] {
      FAC_TWO,
      FAC_THREE,
      FAC_FIVE
   } nrn_factor_type;

   // Child chosen during one sift-down level.
   typedef enum logic [1:0] {
      SEL_NONE,
      SEL_LEFT,
      SEL_RIGHT
   } nrn_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_ROUND,
      ST_TOP_RD,
      ST_TOP_CHK,
      ST_SIFT_LOAD,
      ST_SD_L,
      ST_SD_R,
      ST_SD_CMP,
      ST_PUSH_START,
      ST_SU_CHK,
      ST_SU_CMP,
      ST_PUSH_NEXT,
      ST_DONE
   } nrn_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } nrn_status_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] regular_value;
      logic                 index_too_large;
   } nrn_result_type;

endpackage

@@ hw/rtl/nrn_ram.sv @@
// nrn_ram: single-port candidate heap store, registered read.
// No dependencies; instantiated by nrn_seq.
module nrn_ram #(
   parameter int DEPTH = 16384,
   parameter int WIDTH = 48,
   localparam int AddrWidth = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic [AddrWidth-1:0] addr,
   input  logic                 we,
   input  logic [WIDTH-1:0]     wdata,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/nrn_alu.sv @@
// nrn_alu: shared compare and saturating multiply-by-2/3/5 unit.
// Depends on nrn_pkg; instantiated by nrn_seq.
module nrn_alu #(
   parameter int WIDTH = 48
) (
   input  logic [WIDTH-1:0]      op_a,
   input  logic [WIDTH-1:0]      op_b,
   input  nrn_pkg::nrn_factor_type factor,
   output logic                  less,
   output logic                  equal,
   output logic [WIDTH-1:0]      product
);
   import nrn_pkg::*;

   logic [WIDTH+2:0] a_ext;
   logic [WIDTH+2:0] wide;

   assign a_ext = (WIDTH+3)'(op_a);
   assign less  = op_a < op_b;
   assign equal = op_a == op_b;

   always_comb begin
      case (factor)
         FAC_TWO:   wide = a_ext << 1;
         FAC_THREE: wide = (a_ext << 1) + a_ext;
         FAC_FIVE:  wide = (a_ext << 2) + a_ext;
         default:   wide = '0;
      endcase
   end

   // saturate to all ones when the product leaves the value range
   assign product = (wide[WIDTH+2:WIDTH] != 3'b000) ? '1 : wide[WIDTH-1:0];

endmodule

@@ hw/rtl/nrn_seq.sv @@
// nrn_seq: sequencer that runs the min-heap rounds over the heap store.
// Depends on nrn_pkg, nrn_ram and nrn_alu; instantiated by nth_regular_number.
module nrn_seq #(
   parameter int MAX_N       = 4095,
   parameter int HEAP_DEPTH  = 16384,
   parameter int VALUE_WIDTH = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [nrn_pkg::N_WIDTH-1:0] index_n,
   input  logic                        res_ack,
   output nrn_pkg::nrn_status_type     status,
   output nrn_pkg::nrn_result_type     result
);
   import nrn_pkg::*;

   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int IW = AW + 2;

   nrn_state_type          state_ff, state_in;
   logic [N_WIDTH-1:0]     n_ff, n_in;
   logic [N_WIDTH-1:0]     round_ff, round_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [VALUE_WIDTH-1:0] cur_ff, cur_in;
   logic [VALUE_WIDTH-1:0] x_ff, x_in;
   logic [VALUE_WIDTH-1:0] min_ff, min_in;
   nrn_sel_type            sel_ff, sel_in;
   logic [AW-1:0]          pos_ff, pos_in;
   logic                   first_ff, first_in;
   nrn_factor_type         fac_ff, fac_in;
   logic                   flag_ff, flag_in;

   logic [AW-1:0]          mem_addr;
   logic                   mem_we;
   logic [VALUE_WIDTH-1:0] mem_wdata;
   logic [VALUE_WIDTH-1:0] mem_rdata;

   logic [VALUE_WIDTH-1:0] alu_a, alu_b, alu_prod;
   nrn_factor_type         alu_fac;
   logic                   alu_less, alu_equal;

   logic [IW-1:0]          l_idx, r_idx, count_ext;
   logic [AW-1:0]          up_idx;
   logic [CW-1:0]          count_dec;
   logic                   full, too_large, take_r;
   logic [63:0]            cur_wide;

   nrn_ram #(.DEPTH(HEAP_DEPTH), .WIDTH(VALUE_WIDTH)) u_ram (
      .clock (clock),
      .addr  (mem_addr),
      .we    (mem_we),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   nrn_alu #(.WIDTH(VALUE_WIDTH)) u_alu (
      .op_a    (alu_a),
      .op_b    (alu_b),
      .factor  (alu_fac),
      .less    (alu_less),
      .equal   (alu_equal),
      .product (alu_prod)
   );

   assign l_idx     = {1'b0, pos_ff, 1'b1};
   assign r_idx     = l_idx + IW'(1);
   assign count_ext = IW'(count_ff);
   assign up_idx    = (pos_ff - AW'(1)) >> 1;
   assign count_dec = count_ff - CW'(1);
   assign full      = count_ff >= CW'(HEAP_DEPTH);
   assign too_large = LIMIT_WIDTH'(index_n) > LIMIT_WIDTH'(MAX_N);
   assign take_r    = (r_idx < count_ext) && alu_less;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         n_ff     <= '0;
         round_ff <= '0;
         count_ff <= '0;
         cur_ff   <= VALUE_WIDTH'(1);
         sel_ff   <= SEL_NONE;
         pos_ff   <= '0;
         first_ff <= 1'b0;
         fac_ff   <= FAC_TWO;
         flag_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         round_ff <= round_in;
         count_ff <= count_in;
         cur_ff   <= cur_in;
         sel_ff   <= sel_in;
         pos_ff   <= pos_in;
         first_ff <= first_in;
         fac_ff   <= fac_in;
         flag_ff  <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      min_ff <= min_in;
   end

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      round_in  = round_ff;
      count_in  = count_ff;
      cur_in    = cur_ff;
      x_in      = x_ff;
      min_in    = min_ff;
      sel_in    = sel_ff;
      pos_in    = pos_ff;
      first_in  = first_ff;
      fac_in    = fac_ff;
      flag_in   = flag_ff;
      mem_addr  = pos_ff;
      mem_we    = 1'b0;
      mem_wdata = x_ff;
      alu_a     = cur_ff;
      alu_b     = x_ff;
      alu_fac   = fac_ff;
      status    = '{busy: 1'b1, done: 1'b0};

      case (state_ff)
         ST_IDLE: begin
            status.busy = 1'b0;
            if (start) begin
               n_in    = index_n;
               flag_in = too_large;
               state_in = too_large ? ST_DONE : ST_INIT;
            end
         end
         ST_INIT: begin
            mem_addr  = '0;
            mem_we    = 1'b1;
            mem_wdata = VALUE_WIDTH'(1);
            count_in  = CW'(1);
            cur_in    = VALUE_WIDTH'(1);
            round_in  = '0;
            state_in  = ST_ROUND;
         end
         ST_ROUND: begin
            if (round_ff == n_ff) begin
               state_in = ST_DONE;
            end else begin
               first_in = 1'b1;
               state_in = ST_TOP_RD;
            end
         end
         ST_TOP_RD: begin
            mem_addr = '0;
            if (count_ff == '0) begin
               fac_in   = FAC_TWO;
               state_in = ST_PUSH_START;
            end else begin
               state_in = ST_TOP_CHK;
            end
         end
         ST_TOP_CHK: begin
            alu_a = mem_rdata;
            alu_b = cur_ff;
            if (first_ff) begin
               cur_in   = mem_rdata;
               first_in = 1'b0;
            end
            if (first_ff || alu_equal) begin
               // drop the root; refill it from the last entry
               count_in = count_dec;
               mem_addr = count_dec[AW-1:0];
               state_in = (count_dec == '0) ? ST_TOP_RD : ST_SIFT_LOAD;
            end else begin
               fac_in   = FAC_TWO;
               state_in = ST_PUSH_START;
            end
         end
         ST_SIFT_LOAD: begin
            x_in     = mem_rdata;
            pos_in   = '0;
            state_in = ST_SD_L;
         end
         ST_SD_L: begin
            if (l_idx >= count_ext) begin
               mem_we   = 1'b1;
               state_in = ST_TOP_RD;
            end else begin
               mem_addr = l_idx[AW-1:0];
               state_in = ST_SD_R;
            end
         end
         ST_SD_R: begin
            alu_a = mem_rdata;
            alu_b = x_ff;
            if (alu_less) begin
               min_in = mem_rdata;
               sel_in = SEL_LEFT;
            end else begin
               min_in = x_ff;
               sel_in = SEL_NONE;
            end
            if (r_idx < count_ext) begin
               mem_addr = r_idx[AW-1:0];
            end
            state_in = ST_SD_CMP;
         end
         ST_SD_CMP: begin
            alu_a  = mem_rdata;
            alu_b  = min_ff;
            mem_we = 1'b1;
            if (take_r) begin
               mem_wdata = mem_rdata;
               pos_in    = r_idx[AW-1:0];
               state_in  = ST_SD_L;
            end else if (sel_ff == SEL_LEFT) begin
               mem_wdata = min_ff;
               pos_in    = l_idx[AW-1:0];
               state_in  = ST_SD_L;
            end else begin
               state_in = ST_TOP_RD;
            end
         end
         ST_PUSH_START: begin
            if (full) begin
               state_in = ST_PUSH_NEXT;
            end else begin
               x_in     = alu_prod;
               pos_in   = count_ff[AW-1:0];
               count_in = count_ff + CW'(1);
               state_in = ST_SU_CHK;
            end
         end
         ST_SU_CHK: begin
            if (pos_ff == '0) begin
               mem_we   = 1'b1;
               state_in = ST_PUSH_NEXT;
            end else begin
               mem_addr = up_idx;
               state_in = ST_SU_CMP;
            end
         end
         ST_SU_CMP: begin
            alu_a  = x_ff;
            alu_b  = mem_rdata;
            mem_we = 1'b1;
            if (alu_less) begin
               mem_wdata = mem_rdata;
               pos_in    = up_idx;
               state_in  = ST_SU_CHK;
            end else begin
               state_in = ST_PUSH_NEXT;
            end
         end
         ST_PUSH_NEXT: begin
            if (fac_ff == FAC_FIVE) begin
               round_in = round_ff + N_WIDTH'(1);
               state_in = ST_ROUND;
            end else begin
               fac_in   = (fac_ff == FAC_TWO) ? FAC_THREE : FAC_FIVE;
               state_in = ST_PUSH_START;
            end
         end
         ST_DONE: begin
            status.done = 1'b1;
            if (res_ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign cur_wide = 64'(cur_ff);
   assign result.regular_value   = flag_ff ? '0 : cur_wide[OUT_WIDTH-1:0];
   assign result.index_too_large = flag_ff;

   a_flag_fast: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start && too_large)
      |=> (state_ff == ST_DONE && result.index_too_large))
      else $error("flagged index did not complete at once");

   a_pos_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SD_L || state_ff == ST_SU_CHK) |-> (CW'(pos_ff) < count_ff))
      else $error("sift position outside live heap");

   a_min_monotone: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TOP_CHK && first_ff && round_ff != '0) |-> (mem_rdata >= cur_ff))
      else $error("heap minimum went below previous value");

endmodule

@@ hw/rtl/nth_regular_number.sv @@
// nth_regular_number: top level, returns the n-th number whose only prime
// factors are 2, 3 and 5. Depends on nrn_pkg and nrn_seq.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_index_n[11:0]
//   rsp      out        rsp_valid/rsp_stall  rsp_regular_value[47:0], rsp_index_too_large
//
// Operation: an index above MAX_N goes straight to a flagged result, with no
// rounds run. Otherwise a word runs index_n rounds on a binary min-heap held
// in one single-port memory. A round removes the root, and every entry equal
// to it, by sift-down, then pushes that value times 2, 3 and 5 by sift-up.
// The one memory port allows one access per cycle.
// Reset: synchronous, active high; the heap store needs no clearing pass,
// since every request rebuilds it from an empty heap.
// Stalls: req_stall is high until a word's result is handed on. A finished
// result sits in the output register; the next request is taken while it
// waits, and that request holds its own result until the register is free.
module nth_regular_number #(
   parameter int MAX_N       = 4095,
   parameter int HEAP_DEPTH  = 16384,
   parameter int VALUE_WIDTH = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [nrn_pkg::N_WIDTH-1:0]   req_index_n,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [nrn_pkg::OUT_WIDTH-1:0] rsp_regular_value,
   output logic                          rsp_index_too_large
);
   import nrn_pkg::*;

   nrn_status_type       status;
   nrn_result_type       result;
   logic                 start;
   logic                 res_ack;
   logic                 out_free;

   logic                 rsp_valid_ff;
   logic [OUT_WIDTH-1:0] rsp_value_ff;
   logic                 rsp_flag_ff;

   // take a word only when the sequencer is idle
   assign req_stall = status.busy;
   assign start     = req_valid && !status.busy;

   nrn_seq #(
      .MAX_N       (MAX_N),
      .HEAP_DEPTH  (HEAP_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .index_n (req_index_n),
      .res_ack (res_ack),
      .status  (status),
      .result  (result)
   );

   // the output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign res_ack  = status.done && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ack) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // hold the payload while stalled; load only on a handoff
   always_ff @(posedge clock) begin
      if (res_ack) begin
         rsp_value_ff <= result.regular_value;
         rsp_flag_ff  <= result.index_too_large;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_regular_value   = rsp_value_ff;
   assign rsp_index_too_large = rsp_flag_ff;

endmodule
